### rtl/core/eeseq_pkg.sv
// Shared types and codes for the SPI EEPROM transaction sequencer
package eeseq_pkg;

	// input item kinds
	localparam logic [1:0] ACT_LOAD     = 2'd0;
	localparam logic [1:0] ACT_START_WR = 2'd1;
	localparam logic [1:0] ACT_START_RD = 2'd2;
	localparam logic [1:0] ACT_RX       = 2'd3;

	// result kinds
	localparam logic [2:0] K_TX    = 3'd0;
	localparam logic [2:0] K_CSHI  = 3'd1;
	localparam logic [2:0] K_CSLO  = 3'd2;
	localparam logic [2:0] K_RDATA = 3'd3;
	localparam logic [2:0] K_DONE  = 3'd4;

	// EEPROM opcodes and status handling
	localparam logic [7:0] CMD_RDSR     = 8'h05;
	localparam logic [7:0] CMD_WREN     = 8'h06;
	localparam logic [7:0] CMD_READ     = 8'h03;
	localparam logic [7:0] CMD_WRITE    = 8'h02;
	localparam logic [7:0] WIP_BIT      = 8'h01;
	localparam logic [7:0] STATUS_DUMMY = 8'h61;

	typedef enum logic [10:0] {
		PH_IDLE       = 11'b000_0000_0001,
		PH_RDSR_ECHO  = 11'b000_0000_0010,
		PH_STATUS     = 11'b000_0000_0100,
		PH_WREN_ECHO  = 11'b000_0000_1000,
		PH_READ_ECHO  = 11'b000_0001_0000,
		PH_WRITE_ECHO = 11'b000_0010_0000,
		PH_RADDR_HI   = 11'b000_0100_0000,
		PH_WADDR_HI   = 11'b000_1000_0000,
		PH_RADDR_LO   = 11'b001_0000_0000,
		PH_WDATA      = 11'b010_0000_0000,
		PH_RDATA      = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic        write_mode;
		logic [15:0] addr;
		logic [6:0]  total;
		logic [6:0]  pos;
	} seq_state_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] value;
	} result_t;

endpackage

### rtl/core/eeseq_ram.sv
// Generic single-write, single-read RAM with registered read data
module eeseq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port (read returns old data on collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/eeseq_step.sv
// One sequencer step: next state and up to three results for one item
module eeseq_step #(
	parameter int BUFFER_BYTES = 64
) (
	input  eeseq_pkg::seq_state_t           st,
	input  logic [1:0]                      action,
	input  logic [15:0]                     address,
	input  logic [6:0]                      count,
	input  logic [7:0]                      data,
	input  logic [7:0]                      buf_byte,
	output eeseq_pkg::seq_state_t           nxt,
	output logic [1:0]                      n_res,
	output eeseq_pkg::result_t [2:0]        res
);
	import eeseq_pkg::*;

	localparam logic [8:0] BUF_LIMIT = 9'(BUFFER_BYTES);

	logic [6:0] total_clamped;
	logic [6:0] pos_inc;
	logic       wdata_more;

	assign total_clamped = ({2'b00, count} > BUF_LIMIT) ? BUF_LIMIT[6:0] : count;
	assign pos_inc       = st.pos + 7'd1;
	assign wdata_more    = (st.pos < st.total) && ({2'b00, st.pos} < BUF_LIMIT);

	// phase machine, results in order in res[0..n_res-1]
	always_comb begin
		nxt   = st;
		n_res = 2'd0;
		res   = '0;
		if (action == ACT_START_WR || action == ACT_START_RD) begin
			if (st.phase == PH_IDLE) begin
				nxt.write_mode = (action == ACT_START_WR);
				nxt.addr       = address;
				nxt.total      = total_clamped;
				nxt.pos        = 7'd0;
				nxt.phase      = PH_RDSR_ECHO;
				res[0]         = '{kind: K_CSLO, value: 8'h00};
				res[1]         = '{kind: K_TX, value: CMD_RDSR};
				n_res          = 2'd2;
			end
		end else if (action == ACT_RX) begin
			case (st.phase)
				PH_IDLE: begin
				end
				PH_RDSR_ECHO: begin
					res[0]    = '{kind: K_TX, value: STATUS_DUMMY};
					n_res     = 2'd1;
					nxt.phase = PH_STATUS;
				end
				PH_STATUS: begin
					res[0] = '{kind: K_CSHI, value: 8'h00};
					res[1] = '{kind: K_CSLO, value: 8'h00};
					n_res  = 2'd3;
					if ((data & WIP_BIT) != 8'h00) begin
						res[2]    = '{kind: K_TX, value: CMD_RDSR};
						nxt.phase = PH_RDSR_ECHO;
					end else if (st.write_mode) begin
						res[2]    = '{kind: K_TX, value: CMD_WREN};
						nxt.phase = PH_WREN_ECHO;
					end else begin
						res[2]    = '{kind: K_TX, value: CMD_READ};
						nxt.phase = PH_READ_ECHO;
					end
				end
				PH_WREN_ECHO: begin
					res[0]    = '{kind: K_CSHI, value: 8'h00};
					res[1]    = '{kind: K_CSLO, value: 8'h00};
					res[2]    = '{kind: K_TX, value: CMD_WRITE};
					n_res     = 2'd3;
					nxt.phase = PH_WRITE_ECHO;
				end
				PH_READ_ECHO: begin
					res[0]    = '{kind: K_TX, value: st.addr[15:8]};
					n_res     = 2'd1;
					nxt.phase = PH_RADDR_HI;
				end
				PH_WRITE_ECHO: begin
					res[0]    = '{kind: K_TX, value: st.addr[15:8]};
					n_res     = 2'd1;
					nxt.phase = PH_WADDR_HI;
				end
				PH_RADDR_HI: begin
					res[0]    = '{kind: K_TX, value: st.addr[7:0]};
					n_res     = 2'd1;
					nxt.phase = PH_RADDR_LO;
				end
				PH_WADDR_HI: begin
					res[0]    = '{kind: K_TX, value: st.addr[7:0]};
					n_res     = 2'd1;
					nxt.pos   = 7'd0;
					nxt.phase = PH_WDATA;
				end
				PH_RADDR_LO: begin
					nxt.pos = 7'd0;
					n_res   = 2'd2;
					if (st.total == 7'd0) begin
						res[0]    = '{kind: K_CSHI, value: 8'h00};
						res[1]    = '{kind: K_DONE, value: 8'h00};
						nxt.phase = PH_IDLE;
					end else begin
						res[0]    = '{kind: K_TX, value: data};
						n_res     = 2'd1;
						nxt.phase = PH_RDATA;
					end
				end
				PH_WDATA: begin
					if (wdata_more) begin
						res[0]  = '{kind: K_TX, value: buf_byte};
						n_res   = 2'd1;
						nxt.pos = pos_inc;
					end else begin
						res[0]    = '{kind: K_CSHI, value: 8'h00};
						res[1]    = '{kind: K_DONE, value: 8'h00};
						n_res     = 2'd2;
						nxt.phase = PH_IDLE;
						nxt.pos   = 7'd0;
					end
				end
				PH_RDATA: begin
					res[0]  = '{kind: K_RDATA, value: data};
					nxt.pos = pos_inc;
					if (pos_inc < st.total) begin
						res[1] = '{kind: K_TX, value: data};
						n_res  = 2'd2;
					end else begin
						res[1]    = '{kind: K_CSHI, value: 8'h00};
						res[2]    = '{kind: K_DONE, value: 8'h00};
						n_res     = 2'd3;
						nxt.phase = PH_IDLE;
						nxt.pos   = 7'd0;
					end
				end
				default: begin
					nxt.phase = PH_IDLE;
					nxt.pos   = 7'd0;
				end
			endcase
		end
	end

endmodule

### rtl/core/spi_eeprom_transaction_sequencer_core.sv
// Top level of the SPI EEPROM transaction sequencer
// Master-side sequencer for a 25xx-style SPI EEPROM. Load words fill the
// write buffer (a BUFFER_BYTES-deep RAM); a start word opens a read or write
// transaction and each received SPI byte advances it by one step. A word is
// taken into an input register and handled when the result register is
// free, producing zero to three results (transmit byte, chip select edges,
// read data, done) that go into a result register and leave one per cycle on
// the output while it is ready, the final result of each word flagged by
// tlast. The input accepts one word per cycle as long as the output takes the
// results; a word that yields two or three results holds the input until its
// last result is leaving. The buffer byte for the next write step is
// prefetched from the RAM's registered read port, with a bypass for a load
// written in the cycle before. No clearing pass is needed after reset.
module spi_eeprom_transaction_sequencer_core #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // address[15:0], count[22:16], slot[28:23], data[36:29]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // value[7:0]
	output logic [2:0]  m_tuser,   // kind[2:0]
	output logic        m_tlast
);
	import eeseq_pkg::*;

	localparam int         AW        = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
	localparam logic [8:0] BUF_LIMIT = 9'(BUFFER_BYTES);

	// input register
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [15:0] address_s1;
	logic [6:0]  count_s1;
	logic [5:0]  slot_s1;
	logic [7:0]  data_s1;

	// sequencer state and result burst
	seq_state_t       st_q;
	seq_state_t       st_d;
	seq_state_t       nxt;
	result_t [2:0]    res_q;
	result_t [2:0]    res_new;
	logic [1:0]       rem_q;
	logic [1:0]       n_res;

	// buffer RAM and write bypass
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [AW-1:0]   ram_raddr;
	logic [7:0]      ram_rdata;
	logic            wr_hit_q;
	logic [AW-1:0]   wr_addr_q;
	logic [7:0]      wr_data_q;
	logic [AW-1:0]   rd_addr_q;
	logic [7:0]      buf_byte;
	logic [8:0]      slot_ext;
	logic [8:0]      pos_ext;

	logic in_fire;
	logic out_fire;
	logic burst_free;
	logic proc;

	// handshake and flow control
	assign out_fire   = m_tvalid && m_tready;
	assign burst_free = (rem_q == 2'd0) || ((rem_q == 2'd1) && m_tready);
	assign proc       = valid_s1 && burst_free;
	assign s_tready   = !valid_s1 || proc;
	assign in_fire    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_s1  <= s_tuser;
			address_s1 <= s_tdata[15:0];
			count_s1   <= s_tdata[22:16];
			slot_s1    <= s_tdata[28:23];
			data_s1    <= s_tdata[36:29];
		end
	end

	// buffer writes from load words, reads prefetched at the next byte position
	assign slot_ext  = {3'b000, slot_s1};
	assign pos_ext   = {2'b00, st_d.pos};
	assign ram_we    = proc && (action_s1 == ACT_LOAD) && (slot_ext < BUF_LIMIT);
	assign ram_waddr = slot_ext[AW-1:0];
	assign ram_raddr = pos_ext[AW-1:0];

	eeseq_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (data_s1),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_hit_q <= 1'b0;
		end else begin
			wr_hit_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= ram_waddr;
		wr_data_q <= data_s1;
		rd_addr_q <= ram_raddr;
	end

	assign buf_byte = (wr_hit_q && (wr_addr_q == rd_addr_q)) ? wr_data_q : ram_rdata;

	// step logic
	eeseq_step #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_step (
		.st       (st_q),
		.action   (action_s1),
		.address  (address_s1),
		.count    (count_s1),
		.data     (data_s1),
		.buf_byte (buf_byte),
		.nxt      (nxt),
		.n_res    (n_res),
		.res      (res_new)
	);

	assign st_d = proc ? nxt : st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= PH_IDLE;
			st_q.write_mode <= 1'b0;
			st_q.addr       <= 16'h0000;
			st_q.total      <= 7'd0;
			st_q.pos        <= 7'd0;
		end else begin
			st_q <= st_d;
		end
	end

	// result burst: load a new set or shift out one word per handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (proc) begin
			rem_q <= n_res;
		end else if (out_fire) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_q <= res_new;
		end else if (out_fire) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	assign m_tvalid = (rem_q != 2'd0);
	assign m_tuser  = res_q[0].kind;
	assign m_tdata  = res_q[0].value;
	assign m_tlast  = (rem_q == 2'd1);

`ifndef NO_ASSERTIONS
	// a done marker is always the final result of its word
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == K_DONE)) |-> m_tlast)
		else $error("done result not flagged last");

	// byte position is cleared whenever the sequencer is idle
	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_IDLE) |-> (st_q.pos == 7'd0))
		else $error("byte position nonzero while idle");

	// write data never runs past the byte total
	a_wdata_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_WDATA) |-> (st_q.pos <= st_q.total))
		else $error("write position beyond total");
`endif

endmodule

### tb/tb_spi_eeprom_transaction_sequencer_core.sv
// Self-checking testbench for the SPI EEPROM transaction sequencer core
module tb_spi_eeprom_transaction_sequencer_core;
	import eeseq_pkg::*;

	localparam int BUF_DEPTH   = 64;
	localparam int ITEM_TARGET = 370;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD   = 300;

	typedef struct {
		logic [2:0] kind;
		logic [7:0] value;
		logic       last;
	} spi_result_t;

	// tracks the sequencer state and the results each accepted word must cause
	class eeseq_result_book;
		phase_t      phase;
		bit          write_mode;
		logic [15:0] addr;
		logic [6:0]  total;
		logic [6:0]  pos;
		logic [7:0]  store [BUF_DEPTH];
		bit          loaded [BUF_DEPTH];
		spi_result_t due [$];
		int          mismatches;
		int          checked;
		int          writes_done;
		int          reads_done;
		int          busy_polls;

		function new();
			phase = PH_IDLE;
			write_mode = 1'b0;
			addr = '0;
			total = '0;
			pos = '0;
			mismatches = 0;
			checked = 0;
			writes_done = 0;
			reads_done = 0;
			busy_polls = 0;
			foreach (loaded[i]) loaded[i] = 1'b0;
		endfunction

		function void due_result(logic [2:0] kind, logic [7:0] value);
			spi_result_t r;
			r.kind = kind;
			r.value = value;
			r.last = 1'b0;
			due.push_back(r);
		endfunction

		// chip select up, done marker, back to idle
		function void close_txn();
			due_result(K_CSHI, 8'h00);
			due_result(K_DONE, 8'h00);
			if (write_mode) writes_done++;
			else reads_done++;
			phase = PH_IDLE;
			pos = '0;
		endfunction

		// returns 1 when the word had any effect
		function bit take_word(logic [1:0] act, logic [15:0] adr, logic [6:0] cnt,
				logic [5:0] slot, logic [7:0] dat);
			int n_prev;
			spi_result_t r;
			n_prev = due.size();
			if (act == ACT_LOAD) begin
				if (slot < BUF_DEPTH) begin
					store[slot] = dat;
					loaded[slot] = 1'b1;
				end
				return 1'b1;
			end
			if (act == ACT_START_WR || act == ACT_START_RD) begin
				if (phase == PH_IDLE) begin
					write_mode = (act == ACT_START_WR);
					addr = adr;
					total = (cnt > BUF_DEPTH) ? 7'(BUF_DEPTH) : cnt;
					pos = '0;
					due_result(K_CSLO, 8'h00);
					due_result(K_TX, CMD_RDSR);
					phase = PH_RDSR_ECHO;
				end
			end else begin
				case (phase)
					PH_RDSR_ECHO: begin
						due_result(K_TX, STATUS_DUMMY);
						phase = PH_STATUS;
					end
					PH_STATUS: begin
						due_result(K_CSHI, 8'h00);
						due_result(K_CSLO, 8'h00);
						if ((dat & WIP_BIT) != 8'h00) begin
							busy_polls++;
							due_result(K_TX, CMD_RDSR);
							phase = PH_RDSR_ECHO;
						end else if (write_mode) begin
							due_result(K_TX, CMD_WREN);
							phase = PH_WREN_ECHO;
						end else begin
							due_result(K_TX, CMD_READ);
							phase = PH_READ_ECHO;
						end
					end
					PH_WREN_ECHO: begin
						due_result(K_CSHI, 8'h00);
						due_result(K_CSLO, 8'h00);
						due_result(K_TX, CMD_WRITE);
						phase = PH_WRITE_ECHO;
					end
					PH_READ_ECHO: begin
						due_result(K_TX, addr[15:8]);
						phase = PH_RADDR_HI;
					end
					PH_WRITE_ECHO: begin
						due_result(K_TX, addr[15:8]);
						phase = PH_WADDR_HI;
					end
					PH_RADDR_HI: begin
						due_result(K_TX, addr[7:0]);
						phase = PH_RADDR_LO;
					end
					PH_WADDR_HI: begin
						due_result(K_TX, addr[7:0]);
						pos = '0;
						phase = PH_WDATA;
					end
					PH_RADDR_LO: begin
						pos = '0;
						if (total == 7'd0) close_txn();
						else begin
							due_result(K_TX, dat);
							phase = PH_RDATA;
						end
					end
					PH_WDATA: begin
						if (pos < total && pos < BUF_DEPTH) begin
							due_result(K_TX, store[pos[5:0]]);
							pos = pos + 7'd1;
						end else close_txn();
					end
					PH_RDATA: begin
						// read dummies echo the byte just received
						due_result(K_RDATA, dat);
						pos = pos + 7'd1;
						if (pos < total) due_result(K_TX, dat);
						else close_txn();
					end
					default: ;
				endcase
			end
			if (due.size() > n_prev) begin
				r = due.pop_back();
				r.last = 1'b1;
				due.push_back(r);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_failure(string msg);
			mismatches++;
			if (mismatches <= 10) $display("mismatch: %s", msg);
		endfunction

		function void match_result(logic [2:0] kind, logic [7:0] value, logic last);
			spi_result_t want;
			checked++;
			if (due.size() == 0) begin
				note_failure($sformatf("unexpected result kind %0d value %02h last %0b",
					kind, value, last));
				return;
			end
			want = due.pop_front();
			if (want.kind !== kind || want.value !== value || want.last !== last)
				note_failure($sformatf(
					"expected kind %0d value %02h last %0b, got kind %0d value %02h last %0b",
					want.kind, want.value, want.last, kind, value, last));
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;    // address[15:0], count[22:16], slot[28:23], data[36:29]
	logic [1:0]  s_tuser = ACT_LOAD;    // action[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;     // value[7:0]
	logic [2:0]  m_tuser;     // kind[2:0]
	logic        m_tlast;

	eeseq_result_book book = new();
	int words_sent = 0;
	int items_done = 0;
	int idle_cycles = 0;

	spi_eeprom_transaction_sequencer_core #(
		.BUFFER_BYTES(BUF_DEPTH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #4 clk = ~clk;

	// check every word taken from the output
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			book.match_result(m_tuser, m_tdata, m_tlast);
	end

	// end the run when neither side moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("timeout with %0d results outstanding", book.pending());
			$display("Test completed with failures");
			$finish;
		end
	end

	// output side: random stalls, calm stretches and one long hold-off
	initial begin
		int gap;
		int taken;
		taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == 150)
				gap = LONG_HOLD;
			else if (((taken / 40) % 3) == 1)
				gap = 0;
			else
				gap = $urandom_range(0, 9);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
		end
	end

	// offer one word and wait until the block takes it
	task automatic send_word(input logic [1:0] act, input logic [15:0] adr,
			input logic [6:0] cnt, input logic [5:0] slot, input logic [7:0] dat);
		int gap;
		gap = (((words_sent / 30) % 3) == 2) ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {3'b000, dat, slot, cnt, adr};
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (book.take_word(act, adr, cnt, slot, dat)) items_done++;
	endtask

	// stop offering until every expected result is out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (book.pending() != 0);
	endtask

	// one full transaction: start word, then received bytes until back in idle
	task automatic run_transaction(input bit wr, input logic [15:0] adr,
			input logic [6:0] cnt, input int busy_polls, input bit collide);
		int polls;
		int need;
		logic [7:0] rx;
		polls = busy_polls;
		need = (cnt > BUF_DEPTH) ? BUF_DEPTH : int'(cnt);
		// every byte the write will send must sit in the buffer first
		if (wr)
			for (int i = 0; i < need; i++)
				if (!book.loaded[i])
					send_word(ACT_LOAD, 16'($urandom), 7'($urandom), 6'(i), 8'($urandom));
		send_word(wr ? ACT_START_WR : ACT_START_RD, adr, cnt,
			6'($urandom), 8'($urandom));
		if (collide)
			send_word(wr ? ACT_START_RD : ACT_START_WR, 16'($urandom), 7'($urandom),
				6'($urandom), 8'($urandom));
		while (book.phase != PH_IDLE) begin
			// stray loads and starts in the middle of a transaction
			if ($urandom_range(0, 11) == 0) begin
				if ($urandom_range(0, 1) == 1)
					send_word(ACT_LOAD, 16'($urandom), 7'($urandom), 6'($urandom),
						8'($urandom));
				else
					send_word(($urandom_range(0, 1) == 1) ? ACT_START_WR : ACT_START_RD,
						16'($urandom), 7'($urandom), 6'($urandom), 8'($urandom));
			end
			rx = 8'($urandom);
			if (book.phase == PH_STATUS) begin
				rx[0] = (polls > 0);
				if (polls > 0) polls--;
			end
			send_word(ACT_RX, 16'($urandom), 7'($urandom), 6'($urandom), rx);
		end
	endtask

	// reset, directed words, random transactions, final drain
	initial begin
		int tx_no;
		bit wr;
		logic [6:0] cnt;
		bit paused;
		tx_no = 0;
		paused = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load field extremes and a received byte while idle
		send_word(ACT_LOAD, 16'h0000, 7'd0, 6'd63, 8'h00);
		send_word(ACT_LOAD, 16'hFFFF, 7'h7F, 6'd0, 8'hFF);
		send_word(ACT_RX, 16'hFFFF, 7'h7F, 6'h3F, 8'hFF);
		// one-byte write to the top address with a busy poll and a start while busy
		run_transaction(1'b1, 16'hFFFF, 7'd1, 1, 1'b1);
		// zero-byte read from address zero
		run_transaction(1'b0, 16'h0000, 7'd0, 0, 1'b0);
		drain();

		while (items_done < ITEM_TARGET) begin
			if ($urandom_range(0, 9) < 8) begin
				wr = 1'($urandom_range(0, 1));
				cnt = ($urandom_range(0, 15) == 0) ? 7'd0 : 7'($urandom_range(1, 8));
				// zero-byte write and oversized counts once each
				if (tx_no == 1) begin
					wr = 1'b1;
					cnt = 7'd0;
				end else if (tx_no == 2) begin
					wr = 1'b0;
					cnt = 7'h7F;
				end else if (tx_no == 5) begin
					wr = 1'b1;
					cnt = 7'd100;
				end
				run_transaction(wr, 16'($urandom), cnt,
					($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0,
					$urandom_range(0, 9) == 0);
				tx_no++;
			end else if ($urandom_range(0, 1) == 1) begin
				send_word(ACT_LOAD, 16'($urandom), 7'($urandom), 6'($urandom), 8'($urandom));
			end else begin
				send_word(ACT_RX, 16'($urandom), 7'($urandom), 6'($urandom), 8'($urandom));
			end
			if (items_done >= 200 && !paused) begin
				drain();
				paused = 1'b1;
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("ran %0d words: %0d writes and %0d reads finished, %0d busy status polls",
			words_sent, book.writes_done, book.reads_done, book.busy_polls);
		$display("%0d output words checked, %0d mismatches", book.checked, book.mismatches);
		if (book.mismatches == 0 && book.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
